/* src/nau_pkg.sv */
// Shared types, constants and the Q32 product helper for the activation unit.
// Used by neural_activation_unit and nau_div; no other dependencies.
package nau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int QW         = 34;   // unsigned Q32 working width
   localparam int NUM_W      = 64;   // divider dividend
   localparam int DEN_W      = 33;   // divider divisor
   localparam int QUO_W      = 33;   // divider quotient
   localparam int RW         = 40;   // signed result before clipping
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   localparam int EXP_TERMS = 13;
   localparam int LOG_TERMS = 12;
   localparam int EXP_LIMIT = 24;
   localparam int EXP_N_MAX = 34;

   localparam logic [QW-1:0] ONE_Q32    = 34'h1_0000_0000;
   localparam logic [QW-1:0] LN2_Q32    = 34'd2977044472;
   localparam logic [QW-1:0] SELU_SCALE = 34'd4512726379;
   localparam logic [QW-1:0] SELU_LA    = 34'd7550979172;

   localparam logic [2:0] FN_LOGSIG   = 3'd0;
   localparam logic [2:0] FN_SELU     = 3'd1;
   localparam logic [2:0] FN_SIGMOID  = 3'd2;
   localparam logic [2:0] FN_SOFTPLUS = 3'd3;
   localparam logic [2:0] FN_SOFTSIGN = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_FUNC = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT  = 2'd2;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sample;
      logic signed [DATA_WIDTH-1:0] upstream_grad;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         saturated;
   } rsp_type;

   // round(a * b / 2^32), ties up
   function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
      logic [2*QW-1:0] p;
      p = a * b;
      p = p + (2*QW)'(32'h8000_0000);
      return p[QW+31:32];
   endfunction

endpackage

/* src/neural_activation_unit.sv */
// Activation unit: log-sigmoid, SELU, sigmoid, softplus, softsign and their gradients.
// Pipeline depth: 92 register stages between an accepted item and rsp_valid.
// Throughput: one item per cycle unless rsp_stall holds the output; the depth comes
// from the 33-stage divider and the two series pipelines (exp, then log1p), two stages per term.
// A stalled result freezes the whole pipeline. Synchronous reset clears all valid
// bits and sets sigmoid, forward direction, cutoff off. Depends on nau_pkg, nau_div.
module neural_activation_unit
   import nau_pkg::*;
#(
   parameter int FRAC_BITS = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int TW       = 37;  // exp argument in Q32, below 24 * 2^32
   localparam int NW       = 6;   // ln2 multiple count
   localparam int SHIFT_IN = 32 - FRAC_BITS;
   localparam logic [31:0]   EXP_LIMIT_A = 32'(EXP_LIMIT) << FRAC_BITS;
   localparam logic [QW-1:0] EPS         = ONE_Q32 >> FRAC_BITS;
   localparam logic [QW+3:0] ROUND_OUT   = (QW+4)'(1) << (31 - FRAC_BITS);
   localparam logic signed [RW-1:0] OUT_HI = RW'((2**(DATA_WIDTH-1)) - 1);
   localparam logic signed [RW-1:0] OUT_LO = -OUT_HI - RW'(1);
   localparam logic signed [RW-1:0] SIG_TOP = RW'((2**FRAC_BITS) - 1);

   typedef struct packed {
      logic                         neg;
      logic signed [DATA_WIDTH-1:0] x;
      logic signed [DATA_WIDTH-1:0] dy;
      logic [DATA_WIDTH-1:0]        a;   // |x|
   } ctx_type;

   typedef struct packed {
      ctx_type       ctx;
      logic          ez;   // argument past the exp limit
      logic [NW-1:0] n;
      logic [TW-1:0] t;
   } red_type;

   typedef struct packed {
      ctx_type       ctx;
      logic          ez;
      logic [NW-1:0] n;
      logic [QW-1:0] r;
      logic [QW-1:0] term;
      logic [QW-1:0] s;
   } tay_type;

   typedef struct packed {
      ctx_type       ctx;
      logic [QW-1:0] u;
   } side_type;

   typedef struct packed {
      ctx_type       ctx;
      logic [QW-1:0] u;
      logic [QW-1:0] rc;
      logic [QW-1:0] z2;
      logic [QW-1:0] p;
      logic [QW+1:0] sum;
   } log_type;

   typedef struct packed {
      ctx_type       ctx;
      logic [QW-1:0] m1;
      logic [QW-1:0] sp_sig;
      logic [QW-1:0] sp_ls;
      logic [QW+2:0] lg;
   } f1_type;

   typedef struct packed {
      logic signed [RW-1:0] fwd;
      logic [QW-1:0]        m2;
      logic                 dy_neg;
      logic                 clamp;
   } f2_type;

   // Q32 to output format, half away from zero on the magnitude
   function automatic logic signed [RW-1:0] to_frac(input logic [QW+2:0] v);
      logic [QW+3:0] t;
      t = {1'b0, v} + ROUND_OUT;
      return RW'(t >> SHIFT_IN);
   endfunction

   // ---------------------------------------------------------------- config
   logic [2:0] func_ff, func_in;
   logic       dir_ff, dir_in;
   logic       cut_ff, cut_in;

   always_comb begin
      func_in = func_ff;
      dir_in  = dir_ff;
      cut_in  = cut_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FUNC: func_in = csr_wdata;
            CSR_DIR:  dir_in  = csr_wdata[0];
            CSR_CUT:  cut_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         func_ff <= FN_SIGMOID;
         dir_ff  <= 1'b0;
         cut_ff  <= 1'b0;
      end else begin
         func_ff <= func_in;
         dir_ff  <= dir_in;
         cut_ff  <= cut_in;
      end
   end

   // ---------------------------------------------------------------- flow
   // One enable for every stage: the pipe moves unless the output is held.
   logic adv;
   logic out_vld_ff;
   rsp_type out_ff, out_in;

   assign adv       = !(out_vld_ff && rsp_stall);
   assign req_stall = !adv;

   // ---------------------------------------------------------------- s0: |x|, Q32 arg
   red_type s0_ff, s0_in;
   red_type s1_ff, s1_in;
   tay_type s2_ff, s2_in;
   logic    s0_vld_ff, s1_vld_ff, s2_vld_ff;

   always_comb begin
      s0_in.ctx.x   = req_data.sample;
      s0_in.ctx.dy  = req_data.upstream_grad;
      s0_in.ctx.neg = req_data.sample[DATA_WIDTH-1];
      s0_in.ctx.a   = s0_in.ctx.neg ? DATA_WIDTH'(-req_data.sample)
                                    : DATA_WIDTH'(req_data.sample);
      s0_in.ez      = 32'(s0_in.ctx.a) >= EXP_LIMIT_A;
      s0_in.n       = '0;
      s0_in.t       = TW'(s0_in.ctx.a) << SHIFT_IN;
   end

   // s1: n = floor(t / ln2) by threshold compare
   logic [EXP_N_MAX-1:0] th;
   always_comb begin
      for (int j = 0; j < EXP_N_MAX; j++) begin
         th[j] = s0_ff.t >= TW'(LN2_Q32) * TW'(j + 1);
      end
      s1_in   = s0_ff;
      s1_in.n = NW'($countones(th));
   end

   // s2: remainder r, series seeds
   always_comb begin
      s2_in.ctx  = s1_ff.ctx;
      s2_in.ez   = s1_ff.ez;
      s2_in.n    = s1_ff.n;
      s2_in.r    = QW'(s1_ff.t - TW'(LN2_Q32) * TW'(s1_ff.n));
      s2_in.term = ONE_Q32;
      s2_in.s    = ONE_Q32;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   // ---------------------------------------------------------------- e^-r series
   // Two stages per term: Q32 product, then exact divide by k via reciprocal.
   localparam int TAY_N = 2 * EXP_TERMS;
   tay_type          tay_ff [TAY_N];
   tay_type          tay_in [TAY_N];
   logic [TAY_N-1:0] tay_vld_ff;

   for (genvar g = 0; g < TAY_N; g++) begin : g_tay
      localparam int K = g / 2 + 1;
      localparam int L = $clog2(K);
      localparam logic [QW:0] M = (QW+1)'(((64'd1 << (QW + L)) + 64'(K) - 64'd1) / K);
      tay_type       prev;

      if (g == 0) begin : g_first
         assign prev = s2_ff;
      end else begin : g_next
         assign prev = tay_ff[g-1];
      end

      if (g % 2 == 0) begin : g_mul
         always_comb begin
            tay_in[g]      = prev;
            tay_in[g].term = qmul(prev.term, prev.r);
         end
      end else begin : g_dvk
         logic [2*QW+L:0] prod;
         assign prod = prev.term * M;
         always_comb begin
            tay_in[g]      = prev;
            tay_in[g].term = prod[QW+L +: QW];
            if (K % 2 == 1) tay_in[g].s = prev.s - prod[QW+L +: QW];
            else            tay_in[g].s = prev.s + prod[QW+L +: QW];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) tay_ff[g] <= tay_in[g];
      end
   end

   // ---------------------------------------------------------------- u = e^-|x|
   side_type u_ff, u_in;
   logic     u_vld_ff;
   logic [QW:0] sr;

   always_comb begin
      u_in.ctx = tay_ff[TAY_N-1].ctx;
      sr       = {1'b0, tay_ff[TAY_N-1].s};
      if (tay_ff[TAY_N-1].n != '0) begin
         sr = sr + ((QW+1)'(1) << (tay_ff[TAY_N-1].n - NW'(1)));
      end
      u_in.u = QW'(sr >> tay_ff[TAY_N-1].n);
      if (tay_ff[TAY_N-1].ez) u_in.u = '0;
   end

   // ---------------------------------------------------------------- divider operands
   // One division per item: 1/(1+u), the log1p z = h/(1+h), or softsign 1/(1+|x|).
   logic [NUM_W-1:0] d0_num_ff, d0_num_in;
   logic [DEN_W-1:0] d0_den_ff, d0_den_in;
   side_type         d0_side_ff;
   logic             d0_vld_ff;
   logic             sel_log, sel_ss;
   logic [DEN_W-1:0] h;

   always_comb begin
      sel_log = !dir_ff && (func_ff == FN_LOGSIG || func_ff == FN_SOFTPLUS);
      sel_ss  = func_ff == FN_SOFTSIGN;
      h       = DEN_W'(u_ff.u >> 1);
      if (sel_ss) begin
         d0_den_in = (DEN_W'(1) << FRAC_BITS) + DEN_W'(u_ff.ctx.a);
         d0_num_in = (NUM_W'(1) << (FRAC_BITS + 32)) + NUM_W'(d0_den_in >> 1);
      end else if (sel_log) begin
         d0_den_in = DEN_W'(ONE_Q32) + h;
         d0_num_in = (NUM_W'(h) << 32) + NUM_W'(d0_den_in >> 1);
      end else begin
         d0_den_in = DEN_W'(33'h0_8000_0000) + h;
         d0_num_in = {1'b1, {(NUM_W-1){1'b0}}} + NUM_W'(d0_den_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff       <= u_in;
         d0_num_ff  <= d0_num_in;
         d0_den_ff  <= d0_den_in;
         d0_side_ff <= u_ff;
      end
   end

   logic                       dv_vld;
   logic [QUO_W-1:0]           dv_quo;
   logic [$bits(side_type)-1:0] dv_side_raw;
   side_type                   dv_side;

   nau_div #(
      .SIDE_W ($bits(side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (d0_vld_ff),
      .num       (d0_num_ff),
      .den       (d0_den_ff),
      .side_in   (d0_side_ff),
      .out_valid (dv_vld),
      .quo       (dv_quo),
      .side_out  (dv_side_raw)
   );

   assign dv_side = dv_side_raw;

   // ---------------------------------------------------------------- log1p series
   log_type l0_ff, l0_in;
   logic    l0_vld_ff;

   always_comb begin
      l0_in.ctx = dv_side.ctx;
      l0_in.u   = dv_side.u;
      l0_in.rc  = QW'(dv_quo);
      l0_in.z2  = qmul(QW'(dv_quo), QW'(dv_quo));
      l0_in.p   = QW'(dv_quo);
      l0_in.sum = (QW+2)'(dv_quo);
   end

   always_ff @(posedge clock) begin
      if (adv) l0_ff <= l0_in;
   end

   localparam int LOG_N = 2 * LOG_TERMS;
   log_type          lg_ff [LOG_N];
   log_type          lg_in [LOG_N];
   logic [LOG_N-1:0] lg_vld_ff;

   for (genvar g = 0; g < LOG_N; g++) begin : g_log
      localparam int K = 2 * (g / 2 + 1) + 1;
      localparam int L = $clog2(K);
      localparam logic [QW:0] M = (QW+1)'(((64'd1 << (QW + L)) + 64'(K) - 64'd1) / K);
      log_type       prev;

      if (g == 0) begin : g_first
         assign prev = l0_ff;
      end else begin : g_next
         assign prev = lg_ff[g-1];
      end

      if (g % 2 == 0) begin : g_mul
         always_comb begin
            lg_in[g]   = prev;
            lg_in[g].p = qmul(prev.p, prev.z2);
         end
      end else begin : g_dvk
         logic [2*QW+L:0] prod;
         assign prod = prev.p * M;
         always_comb begin
            lg_in[g]     = prev;
            lg_in[g].sum = prev.sum + (QW+2)'(prod[QW+L +: QW]);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) lg_ff[g] <= lg_in[g];
      end
   end

   // ---------------------------------------------------------------- f1: first product
   f1_type        f1_ff, f1_in;
   logic          f1_vld_ff;
   logic [QW-1:0] op_a, op_b;
   logic          x_pos1;

   always_comb begin
      f1_in.ctx    = lg_ff[LOG_N-1].ctx;
      f1_in.lg     = {lg_ff[LOG_N-1].sum, 1'b0};
      f1_in.sp_sig = f1_in.ctx.neg ? ONE_Q32 - lg_ff[LOG_N-1].rc : lg_ff[LOG_N-1].rc;
      f1_in.sp_ls  = f1_in.ctx.neg ? lg_ff[LOG_N-1].rc : ONE_Q32 - lg_ff[LOG_N-1].rc;
      x_pos1       = !f1_in.ctx.neg && f1_in.ctx.a != '0;
      op_a = '0;
      op_b = '0;
      case (func_ff)
         FN_SELU: begin
            op_b = SELU_LA;
            if (x_pos1) begin
               op_a = QW'(f1_in.ctx.a);
               op_b = SELU_SCALE;
            end else if (dir_ff) begin
               op_a = lg_ff[LOG_N-1].u;
            end else begin
               op_a = ONE_Q32 - lg_ff[LOG_N-1].u;
            end
         end
         FN_SIGMOID: begin
            op_a = f1_in.sp_sig;
            op_b = ONE_Q32 - f1_in.sp_sig;
         end
         FN_SOFTSIGN: begin
            op_a = dir_ff ? lg_ff[LOG_N-1].rc : QW'(f1_in.ctx.a);
            op_b = lg_ff[LOG_N-1].rc;
         end
         default: ;
      endcase
      f1_in.m1 = qmul(op_a, op_b);
   end

   always_ff @(posedge clock) begin
      if (adv) f1_ff <= f1_in;
   end

   // ---------------------------------------------------------------- f2: gradient product, forward value
   f2_type                  f2_ff, f2_in;
   logic                    f2_vld_ff;
   logic [QW-1:0]           gain;
   logic [DATA_WIDTH-1:0]   dy_mag;
   logic signed [RW-1:0]    xs;
   logic                    x_pos2, sp_low;

   always_comb begin
      x_pos2 = !f1_ff.ctx.neg && f1_ff.ctx.a != '0;
      xs     = RW'(f1_ff.ctx.x);
      dy_mag = f1_ff.ctx.dy[DATA_WIDTH-1] ? DATA_WIDTH'(-f1_ff.ctx.dy)
                                          : DATA_WIDTH'(f1_ff.ctx.dy);
      sp_low = f1_ff.sp_sig <= EPS;
      f2_in.dy_neg = f1_ff.ctx.dy[DATA_WIDTH-1];
      f2_in.clamp  = cut_ff && func_ff == FN_SIGMOID &&
                     (sp_low || f1_ff.sp_sig >= ONE_Q32 - EPS);
      gain      = '0;
      f2_in.fwd = '0;
      case (func_ff)
         FN_LOGSIG: begin
            gain      = f1_ff.sp_ls;
            f2_in.fwd = (f1_ff.ctx.neg ? xs : RW'(0)) - to_frac(f1_ff.lg);
         end
         FN_SELU: begin
            gain      = x_pos2 ? SELU_SCALE : f1_ff.m1;
            f2_in.fwd = x_pos2 ? $signed(RW'(f1_ff.m1)) : -to_frac((QW+3)'(f1_ff.m1));
         end
         FN_SIGMOID: begin
            gain = f1_ff.m1;
            if (f2_in.clamp) f2_in.fwd = sp_low ? RW'(1) : SIG_TOP;
            else             f2_in.fwd = to_frac((QW+3)'(f1_ff.sp_sig));
         end
         FN_SOFTPLUS: begin
            gain      = f1_ff.sp_sig;
            f2_in.fwd = (f1_ff.ctx.neg ? RW'(0) : xs) + to_frac(f1_ff.lg);
         end
         FN_SOFTSIGN: begin
            gain      = f1_ff.m1;
            f2_in.fwd = f1_ff.ctx.neg ? -$signed(RW'(f1_ff.m1)) : $signed(RW'(f1_ff.m1));
         end
         default: ;   // unassigned selector: zero either way
      endcase
      f2_in.m2 = qmul(QW'(dy_mag), gain);
   end

   always_ff @(posedge clock) begin
      if (adv) f2_ff <= f2_in;
   end

   // ---------------------------------------------------------------- output: select, clip
   logic signed [RW-1:0] res;

   always_comb begin
      if (!dir_ff)          res = f2_ff.fwd;
      else if (f2_ff.clamp) res = '0;
      else if (f2_ff.dy_neg) res = -$signed(RW'(f2_ff.m2));
      else                  res = $signed(RW'(f2_ff.m2));
      out_in.saturated = 1'b0;
      if (res > OUT_HI) begin
         out_in.value     = DATA_WIDTH'(OUT_HI);
         out_in.saturated = 1'b1;
      end else if (res < OUT_LO) begin
         out_in.value     = DATA_WIDTH'(OUT_LO);
         out_in.saturated = 1'b1;
      end else begin
         out_in.value = DATA_WIDTH'(res);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end

   // valid chain outside the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff  <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         tay_vld_ff <= '0;
         u_vld_ff   <= 1'b0;
         d0_vld_ff  <= 1'b0;
         l0_vld_ff  <= 1'b0;
         lg_vld_ff  <= '0;
         f1_vld_ff  <= 1'b0;
         f2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff  <= req_valid;
         s1_vld_ff  <= s0_vld_ff;
         s2_vld_ff  <= s1_vld_ff;
         tay_vld_ff <= {tay_vld_ff[TAY_N-2:0], s2_vld_ff};
         u_vld_ff   <= tay_vld_ff[TAY_N-1];
         d0_vld_ff  <= u_vld_ff;
         l0_vld_ff  <= dv_vld;
         lg_vld_ff  <= {lg_vld_ff[LOG_N-2:0], l0_vld_ff};
         f1_vld_ff  <= lg_vld_ff[LOG_N-1];
         f2_vld_ff  <= f1_vld_ff;
         out_vld_ff <= f2_vld_ff;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // ---------------------------------------------------------------- checks
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.value == DATA_WIDTH'(OUT_HI) || rsp_data.value == DATA_WIDTH'(OUT_LO)))
      else $error("saturated flag set with value off the format limits");

   a_unassigned_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && func_ff > FN_SOFTSIGN) |->
         (rsp_data.value == '0 && !rsp_data.saturated))
      else $error("unassigned function gave a nonzero result");

   a_cutoff_positive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && func_ff == FN_SIGMOID && !dir_ff && cut_ff) |->
         (rsp_data.value > 0))
      else $error("sigmoid with cutoff reached zero or below");

endmodule

/* src/nau_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// carried alongside. Depends on nau_pkg for the operand widths.
module nau_div
   import nau_pkg::*;
#(
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [QUO_W-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);

   localparam int CW = DEN_W + QUO_W;

   logic [NUM_W-1:0]  rem_ff  [QUO_W];
   logic [NUM_W-1:0]  rem_in  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_in  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];
   logic [QUO_W-1:0]  vld_ff;

   for (genvar st = 0; st < QUO_W; st++) begin : g_stage
      localparam int B = QUO_W - 1 - st;
      logic [NUM_W-1:0]  prev_rem;
      logic [QUO_W-1:0]  prev_quo;
      logic [DEN_W-1:0]  prev_den;
      logic [SIDE_W-1:0] prev_side;
      logic [CW-1:0]     shifted;

      if (st == 0) begin : g_first
         assign prev_rem  = num;
         assign prev_quo  = '0;
         assign prev_den  = den;
         assign prev_side = side_in;
      end else begin : g_next
         assign prev_rem  = rem_ff[st-1];
         assign prev_quo  = quo_ff[st-1];
         assign prev_den  = den_ff[st-1];
         assign prev_side = side_ff[st-1];
      end

      always_comb begin
         shifted    = CW'(prev_den) << B;
         rem_in[st] = prev_rem;
         quo_in[st] = prev_quo;
         if (CW'(prev_rem) >= shifted) begin
            rem_in[st]    = NUM_W'(CW'(prev_rem) - shifted);
            quo_in[st][B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[st]  <= rem_in[st];
            quo_ff[st]  <= quo_in[st];
            den_ff[st]  <= prev_den;
            side_ff[st] <= prev_side;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QUO_W-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign side_out  = side_ff[QUO_W-1];

endmodule
